// ===== rtl/smac_pkg.sv =====
// shared types and constants of the sparse matrix assembly block
package smac_pkg;

   localparam int ROW_W      = 8;
   localparam int COL_W_IO   = 8;
   localparam int VAL_W      = 64;
   localparam int REQ_W      = 2;
   localparam int STATUS_W   = 3;
   localparam int INDEX_W    = 12;
   localparam int TOTAL_W    = 13;
   localparam int CSR_DATA_W = 9;
   localparam int CSR_IDX_W  = 1;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [CSR_DATA_W-1:0] COUNT_RESET = 9'd256;

   typedef enum logic [REQ_W-1:0] {
      REQ_INSERT = 2'd0,
      REQ_READ   = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_NOP    = 2'd3
   } req_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_COUNT = 1'b0,
      CSR_COL_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_NEW    = 3'd0,
      ST_MERGED = 3'd1,
      ST_FULL   = 3'd2,
      ST_RANGE  = 3'd3,
      ST_EMPTY  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      OP_INSERT,
      OP_RANGE,
      OP_READ,
      OP_CLEAR,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [ROW_W-1:0]    row;
      logic [COL_W_IO-1:0] col;
      logic [VAL_W-1:0]    value;
   } job_type;

   typedef struct packed {
      status_type          status;
      logic [ROW_W-1:0]    row;
      logic [COL_W_IO-1:0] col;
      logic [VAL_W-1:0]    value;
      logic [INDEX_W-1:0]  index;
      logic                first;
      logic                last;
   } result_type;

endpackage

// ===== rtl/smac_if.sv =====
// channel interfaces: request, response and register write
interface smac_req_if;
   import smac_pkg::*;
   logic                valid;
   logic                ready;
   logic [REQ_W-1:0]    req_type;
   logic [ROW_W-1:0]    row;
   logic [COL_W_IO-1:0] col;
   logic [VAL_W-1:0]    value;
   modport source (output valid, req_type, row, col, value, input ready);
   modport sink (input valid, req_type, row, col, value, output ready);
endinterface

interface smac_rsp_if;
   import smac_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ROW_W-1:0]    out_row;
   logic [COL_W_IO-1:0] out_col;
   logic [VAL_W-1:0]    out_value;
   logic [INDEX_W-1:0]  entry_index;
   logic                col_first;
   logic                last;
   logic [TOTAL_W-1:0]  total_entries;
   modport source (output valid, status, out_row, out_col, out_value, entry_index,
                   col_first, last, total_entries, input ready);
   modport sink (input valid, status, out_row, out_col, out_value, entry_index,
                 col_first, last, total_entries, output ready);
endinterface

interface smac_csr_if;
   import smac_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/smac_ram.sv =====
// generic single write, single read ram with registered read data
module smac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/smac_fadd.sv =====
// multi-cycle ieee double adder, round to nearest even
module smac_fadd (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] sum
);
   typedef enum logic [2:0] {F_IDLE, F_ALIGN, F_ADD, F_NORM, F_ROUND, F_DONE} fstate_type;

   fstate_type  st_ff, st_in;
   logic [63:0] a_ff, a_in, b_ff, b_in, sum_ff, sum_in;
   logic [55:0] big_ff, big_in, small_ff, small_in;
   logic [56:0] man_ff, man_in;
   logic [11:0] exp_ff, exp_in;
   logic        sign_ff, sign_in, sub_ff, sub_in;

   logic        a_nan, b_nan, a_inf, b_inf, a_big;
   logic [63:0] x, y;
   logic [11:0] ex, ey, d;
   logic [55:0] mx, my, mask;
   logic [3:0]  lz, k;
   logic [53:0] rnd;
   logic        up;
   logic [11:0] fexp;

   function automatic logic [3:0] lzc8(input logic [7:0] v);
      logic [3:0] n;
      logic       hit;
      n = 4'd0;
      hit = 1'b0;
      for (int i = 7; i >= 0; i--) begin
         if (!hit && !v[i]) begin
            n = n + 4'd1;
         end else begin
            hit = 1'b1;
         end
      end
      return n;
   endfunction

   always_comb begin
      st_in    = st_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      sum_in   = sum_ff;
      big_in   = big_ff;
      small_in = small_ff;
      man_in   = man_ff;
      exp_in   = exp_ff;
      sign_in  = sign_ff;
      sub_in   = sub_ff;

      a_nan = (a_ff[62:52] == 11'h7FF) && (a_ff[51:0] != 52'd0);
      b_nan = (b_ff[62:52] == 11'h7FF) && (b_ff[51:0] != 52'd0);
      a_inf = (a_ff[62:52] == 11'h7FF) && (a_ff[51:0] == 52'd0);
      b_inf = (b_ff[62:52] == 11'h7FF) && (b_ff[51:0] == 52'd0);
      a_big = a_ff[62:0] >= b_ff[62:0];
      x  = a_big ? a_ff : b_ff;
      y  = a_big ? b_ff : a_ff;
      ex = (x[62:52] == 11'd0) ? 12'd1 : {1'b0, x[62:52]};
      ey = (y[62:52] == 11'd0) ? 12'd1 : {1'b0, y[62:52]};
      mx = {x[62:52] != 11'd0, x[51:0], 3'b000};
      my = {y[62:52] != 11'd0, y[51:0], 3'b000};
      d  = ex - ey;
      mask = ~({56{1'b1}} << d[5:0]);

      lz = lzc8(man_ff[55:48]);
      k  = ((exp_ff - 12'd1) < {8'd0, lz}) ? 4'(exp_ff - 12'd1) : lz;

      up   = man_ff[2] & (man_ff[1] | man_ff[0] | man_ff[3]);
      rnd  = {1'b0, man_ff[55:3]} + {53'd0, up};
      fexp = rnd[53] ? exp_ff + 12'd1 : (rnd[52] ? exp_ff : 12'd0);

      unique case (st_ff)
         F_IDLE: begin
            if (start) begin
               a_in  = op_a;
               b_in  = op_b;
               st_in = F_ALIGN;
            end
         end
         F_ALIGN: begin
            st_in = F_DONE;
            if (a_nan) begin
               sum_in = a_ff | 64'h0008_0000_0000_0000;
            end else if (b_nan) begin
               sum_in = b_ff | 64'h0008_0000_0000_0000;
            end else if (a_inf && b_inf && (a_ff[63] != b_ff[63])) begin
               sum_in = 64'hFFF8_0000_0000_0000;
            end else if (a_inf) begin
               sum_in = a_ff;
            end else if (b_inf) begin
               sum_in = b_ff;
            end else begin
               big_in  = mx;
               sign_in = x[63];
               sub_in  = a_ff[63] ^ b_ff[63];
               exp_in  = ex;
               if (d >= 12'd56) begin
                  small_in = {55'd0, |my};
               end else begin
                  small_in = (my >> d[5:0]) | {55'd0, |(my & mask)};
               end
               st_in = F_ADD;
            end
         end
         F_ADD: begin
            man_in = sub_ff ? {1'b0, big_ff} - {1'b0, small_ff}
                            : {1'b0, big_ff} + {1'b0, small_ff};
            st_in  = F_NORM;
         end
         F_NORM: begin
            if (man_ff[56]) begin
               man_in = {1'b0, man_ff[56:2], man_ff[1] | man_ff[0]};
               exp_in = exp_ff + 12'd1;
               st_in  = F_ROUND;
            end else if (man_ff == 57'd0) begin
               sum_in = {sub_ff ? 1'b0 : sign_ff, 63'd0};
               st_in  = F_DONE;
            end else if (man_ff[55] || exp_ff == 12'd1) begin
               st_in = F_ROUND;
            end else begin
               man_in = man_ff << k;
               exp_in = exp_ff - {8'd0, k};
            end
         end
         F_ROUND: begin
            if (fexp >= 12'd2047) begin
               sum_in = {sign_ff, 11'h7FF, 52'd0};
            end else begin
               sum_in = {sign_ff, fexp[10:0], rnd[53] ? rnd[52:1] : rnd[51:0]};
            end
            st_in = F_DONE;
         end
         F_DONE: begin
            st_in = F_IDLE;
         end
         default: st_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= F_IDLE;
      end else begin
         st_ff <= st_in;
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      sum_ff   <= sum_in;
      big_ff   <= big_in;
      small_ff <= small_in;
      man_ff   <= man_in;
      exp_ff   <= exp_in;
      sign_ff  <= sign_in;
      sub_ff   <= sub_in;
   end

   assign done = (st_ff == F_DONE);
   assign sum  = sum_ff;
endmodule

// ===== rtl/smac_front.sv =====
// front end: register port, request classification and job queue
module smac_front #(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256
) (
   input  logic              clock,
   input  logic              reset,
   smac_req_if.sink          req_bus,
   smac_csr_if.sink          csr_bus,
   output logic              job_vld,
   output smac_pkg::job_type job,
   input  logic              job_rdy
);
   import smac_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CSR_DATA_W-1:0] row_count_ff, col_count_ff;
   job_type               q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]      cnt_ff;
   job_type               new_job;
   logic                  push, pop, in_range;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = (cnt_ff < CNT_W'(QUEUE_DEPTH));
   assign push = req_bus.valid && req_bus.ready;
   assign pop  = job_vld && job_rdy;
   assign job_vld = (cnt_ff != '0);
   assign job = q_ff[rd_ptr_ff];

   always_comb begin
      in_range = ({1'b0, req_bus.row} < row_count_ff) && (32'(req_bus.row) < MAX_ROWS) &&
                 ({1'b0, req_bus.col} < col_count_ff) && (32'(req_bus.col) < MAX_COLS);
      new_job.row   = req_bus.row;
      new_job.col   = req_bus.col;
      new_job.value = req_bus.value;
      unique case (req_code_type'(req_bus.req_type))
         REQ_INSERT: new_job.op = in_range ? OP_INSERT : OP_RANGE;
         REQ_READ:   new_job.op = OP_READ;
         REQ_CLEAR:  new_job.op = OP_CLEAR;
         REQ_NOP:    new_job.op = OP_NOP;
         default:    new_job.op = OP_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= COUNT_RESET;
         col_count_ff <= COUNT_RESET;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         cnt_ff       <= '0;
      end else begin
         if (csr_bus.valid) begin
            unique case (csr_index_type'(csr_bus.index))
               CSR_ROW_COUNT: row_count_ff <= csr_bus.data;
               CSR_COL_COUNT: col_count_ff <= csr_bus.data;
               default: ;
            endcase
         end
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= new_job;
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(QUEUE_DEPTH)) else $error("job queue overfilled");
endmodule

// ===== rtl/smac_back.sv =====
// back end: column stores, sorted insert, merge and compressed read stream
module smac_back #(
   parameter int MAX_COLS    = 256,
   parameter int MAX_PER_COL = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_vld,
   input  smac_pkg::job_type job,
   output logic              job_rdy,
   smac_rsp_if.source        rsp_bus
);
   import smac_pkg::*;

   localparam int SLOTS = MAX_COLS * MAX_PER_COL;
   localparam int SA_W  = $clog2(SLOTS);
   localparam int C_W   = $clog2(MAX_COLS);
   localparam int K_W   = $clog2(MAX_PER_COL + 1);
   localparam int T_W   = $clog2(SLOTS + 1);
   localparam int ENT_W = ROW_W + VAL_W;

   typedef enum logic [3:0] {
      S_IDLE, S_FILL, S_SCAN, S_SHIFT, S_PUT, S_ADD, S_RSCAN, S_RENT, S_OUT
   } state_type;

   state_type     st_ff, st_in;
   job_type       job_ff, job_in;
   logic [K_W-1:0] n_ff, n_in, k_ff, k_in, pos_ff, pos_in, rs_ff, rs_in;
   logic [C_W-1:0] rc_ff, rc_in, rcol_ff, rcol_in;
   logic [K_W-1:0] rslot_ff, rslot_in;
   logic [T_W-1:0] total_ff, total_in, rpos_ff, rpos_in;
   logic           wrap_ff, wrap_in;
   logic [MAX_COLS-1:0] fvld_ff, fvld_in;
   result_type     res_ff, res_in, rsp_ff, rsp_in;
   logic [TOTAL_W-1:0] rtot_ff, rtot_in;
   logic           rvld_ff, rvld_in;

   logic             fill_wr_en, ent_wr_en;
   logic [C_W-1:0]   fill_wr_addr, fill_rd_addr, jcol;
   logic [K_W-1:0]   fill_wr_data, fill_rd_data, fill_val;
   logic [SA_W-1:0]  ent_wr_addr, ent_rd_addr;
   logic [ENT_W-1:0] ent_wr_data, ent_rd_data;
   logic [ROW_W-1:0] ent_row;
   logic             add_start, add_done, col_full;
   logic [63:0]      add_sum;

   function automatic logic [SA_W-1:0] slot(input logic [C_W-1:0] c, input logic [K_W-1:0] s);
      return SA_W'(int'(c) * MAX_PER_COL + int'(s));
   endfunction

   assign jcol     = C_W'(job_ff.col);
   assign ent_row  = ent_rd_data[ENT_W-1 -: ROW_W];
   assign col_full = (32'(n_ff) == MAX_PER_COL);

   smac_ram #(.WIDTH(K_W), .DEPTH(MAX_COLS)) u_fill_ram (
      .clock(clock), .wr_en(fill_wr_en), .wr_addr(fill_wr_addr), .wr_data(fill_wr_data),
      .rd_addr(fill_rd_addr), .rd_data(fill_rd_data));

   smac_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_entry_ram (
      .clock(clock), .wr_en(ent_wr_en), .wr_addr(ent_wr_addr), .wr_data(ent_wr_data),
      .rd_addr(ent_rd_addr), .rd_data(ent_rd_data));

   smac_fadd u_fadd (
      .clock(clock), .reset(reset), .start(add_start), .op_a(ent_rd_data[VAL_W-1:0]),
      .op_b(job_ff.value), .done(add_done), .sum(add_sum));

   always_comb begin
      st_in = st_ff; job_in = job_ff; n_in = n_ff; k_in = k_ff; pos_in = pos_ff;
      rs_in = rs_ff; rc_in = rc_ff; rcol_in = rcol_ff; rslot_in = rslot_ff;
      total_in = total_ff; rpos_in = rpos_ff; wrap_in = wrap_ff; fvld_in = fvld_ff;
      res_in = res_ff; rsp_in = rsp_ff; rtot_in = rtot_ff;
      rvld_in = rvld_ff && !rsp_bus.ready;
      job_rdy = 1'b0;
      fill_wr_en = 1'b0; fill_wr_addr = jcol; fill_wr_data = K_W'(n_ff + 1'b1);
      fill_rd_addr = rc_ff;
      ent_wr_en = 1'b0; ent_wr_addr = slot(jcol, pos_ff);
      ent_wr_data = {job_ff.row, job_ff.value};
      ent_rd_addr = slot(jcol, k_ff);
      add_start = 1'b0;
      fill_val = fvld_ff[rc_ff] ? fill_rd_data : '0;

      unique case (st_ff)
         S_IDLE: begin
            if (job_vld) begin
               job_rdy = 1'b1;
               job_in  = job;
               res_in  = '0;
               res_in.row = job.row;
               res_in.col = job.col;
               unique case (job.op)
                  OP_INSERT: begin
                     fill_rd_addr = C_W'(job.col);
                     rc_in = C_W'(job.col);
                     st_in = S_FILL;
                  end
                  OP_RANGE: begin
                     res_in.status = ST_RANGE;
                     st_in = S_OUT;
                  end
                  OP_READ: begin
                     res_in = '0;
                     if (total_ff == '0) begin
                        res_in.status = ST_EMPTY;
                        st_in = S_OUT;
                     end else begin
                        fill_rd_addr = rcol_ff;
                        rc_in   = rcol_ff;
                        rs_in   = rslot_ff;
                        wrap_in = 1'b0;
                        st_in   = S_RSCAN;
                     end
                  end
                  OP_CLEAR: begin
                     res_in   = '0;
                     fvld_in  = '0;
                     total_in = '0;
                     rcol_in = '0; rslot_in = '0; rpos_in = '0;
                     st_in    = S_OUT;
                  end
                  default: begin
                     res_in = '0;
                     res_in.status = ST_EMPTY;
                     st_in = S_OUT;
                  end
               endcase
            end
         end
         S_FILL: begin
            n_in = fill_val;
            k_in = '0;
            if (fill_val == '0) begin
               pos_in = '0;
               st_in  = S_PUT;
            end else begin
               ent_rd_addr = slot(jcol, '0);
               st_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (ent_row == job_ff.row) begin
               add_start = 1'b1;
               st_in = S_ADD;
            end else if (ent_row > job_ff.row) begin
               if (col_full) begin
                  res_in.status = ST_FULL;
                  st_in = S_OUT;
               end else begin
                  pos_in = k_ff;
                  k_in = K_W'(n_ff - 1'b1);
                  ent_rd_addr = slot(jcol, K_W'(n_ff - 1'b1));
                  st_in = S_SHIFT;
               end
            end else if (K_W'(k_ff + 1'b1) == n_ff) begin
               if (col_full) begin
                  res_in.status = ST_FULL;
                  st_in = S_OUT;
               end else begin
                  pos_in = n_ff;
                  st_in = S_PUT;
               end
            end else begin
               k_in = K_W'(k_ff + 1'b1);
               ent_rd_addr = slot(jcol, K_W'(k_ff + 1'b1));
            end
         end
         S_SHIFT: begin
            ent_wr_en   = 1'b1;
            ent_wr_addr = slot(jcol, K_W'(k_ff + 1'b1));
            ent_wr_data = ent_rd_data;
            if (k_ff == pos_ff) begin
               st_in = S_PUT;
            end else begin
               k_in = K_W'(k_ff - 1'b1);
               ent_rd_addr = slot(jcol, K_W'(k_ff - 1'b1));
            end
         end
         S_PUT: begin
            ent_wr_en = 1'b1;
            fill_wr_en = 1'b1;
            fvld_in[jcol] = 1'b1;
            total_in = T_W'(total_ff + 1'b1);
            rcol_in = '0; rslot_in = '0; rpos_in = '0;
            res_in.status = ST_NEW;
            res_in.value  = job_ff.value;
            st_in = S_OUT;
         end
         S_ADD: begin
            ent_wr_addr = slot(jcol, k_ff);
            ent_wr_data = {job_ff.row, add_sum};
            if (add_done) begin
               ent_wr_en = 1'b1;
               res_in.status = ST_MERGED;
               res_in.value  = add_sum;
               st_in = S_OUT;
            end
         end
         S_RSCAN: begin
            if (rs_ff < fill_val) begin
               ent_rd_addr = slot(rc_ff, rs_ff);
               st_in = S_RENT;
            end else if (32'(rc_ff) == MAX_COLS - 1) begin
               if (wrap_ff) begin
                  res_in = '0;
                  res_in.status = ST_EMPTY;
                  st_in = S_OUT;
               end else begin
                  wrap_in = 1'b1;
                  rc_in = '0; rs_in = '0; rpos_in = '0;
                  fill_rd_addr = '0;
               end
            end else begin
               rc_in = C_W'(rc_ff + 1'b1);
               rs_in = '0;
               fill_rd_addr = C_W'(rc_ff + 1'b1);
            end
         end
         S_RENT: begin
            res_in.status = ST_NEW;
            res_in.row    = ent_row;
            res_in.col    = COL_W_IO'(rc_ff);
            res_in.value  = ent_rd_data[VAL_W-1:0];
            res_in.index  = INDEX_W'(rpos_ff);
            res_in.first  = (rs_ff == '0);
            res_in.last   = (T_W'(rpos_ff + 1'b1) >= total_ff);
            if (T_W'(rpos_ff + 1'b1) >= total_ff) begin
               rcol_in = '0; rslot_in = '0; rpos_in = '0;
            end else begin
               rcol_in  = rc_ff;
               rslot_in = K_W'(rs_ff + 1'b1);
               rpos_in  = T_W'(rpos_ff + 1'b1);
            end
            st_in = S_OUT;
         end
         S_OUT: begin
            if (!rvld_ff || rsp_bus.ready) begin
               rsp_in  = res_ff;
               rtot_in = TOTAL_W'(total_ff);
               rvld_in = 1'b1;
               st_in   = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_IDLE;
         total_ff <= '0;
         rcol_ff  <= '0;
         rslot_ff <= '0;
         rpos_ff  <= '0;
         fvld_ff  <= '0;
         rvld_ff  <= 1'b0;
      end else begin
         st_ff    <= st_in;
         total_ff <= total_in;
         rcol_ff  <= rcol_in;
         rslot_ff <= rslot_in;
         rpos_ff  <= rpos_in;
         fvld_ff  <= fvld_in;
         rvld_ff  <= rvld_in;
      end
      job_ff  <= job_in;
      n_ff    <= n_in;
      k_ff    <= k_in;
      pos_ff  <= pos_in;
      rs_ff   <= rs_in;
      rc_ff   <= rc_in;
      wrap_ff <= wrap_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
      rtot_ff <= rtot_in;
   end

   assign rsp_bus.valid         = rvld_ff;
   assign rsp_bus.status        = rsp_ff.status;
   assign rsp_bus.out_row       = rsp_ff.row;
   assign rsp_bus.out_col       = rsp_ff.col;
   assign rsp_bus.out_value     = rsp_ff.value;
   assign rsp_bus.entry_index   = rsp_ff.index;
   assign rsp_bus.col_first     = rsp_ff.first;
   assign rsp_bus.last          = rsp_ff.last;
   assign rsp_bus.total_entries = rtot_ff;

   a_fill_wr: assert property (@(posedge clock) disable iff (reset)
      fill_wr_en |-> st_ff == S_PUT) else $error("column fill written outside insert");
   a_total_inc: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_PUT |=> total_ff == T_W'($past(total_ff) + 1'b1))
      else $error("entry total not advanced on new entry");
   a_ent_wr: assert property (@(posedge clock) disable iff (reset)
      ent_wr_en |-> (st_ff == S_SHIFT || st_ff == S_PUT || (st_ff == S_ADD && add_done)))
      else $error("entry store written in wrong state");
endmodule

// ===== rtl/sparse_matrix_assembly_csc.sv =====
// top level of the sparse matrix assembly block
// Stamps are accumulated into per-column stores kept in row order, with duplicates
// summed in IEEE double. Each transaction gives one response. An insert scans the
// column entry by entry and, when it does not land at the end, moves each later
// entry up one slot, as the entry ram has a single read port. A merge stops the
// scan at the match and waits on the iterative double adder (which takes a shorter
// path for nan or infinite operands) in place of the single write. A read walks the
// column fill ram one column per cycle until it finds the next entry. Clear, no-op,
// reads of an empty store and rejected stamps go straight to the response. Up to two
// transactions queue ahead of the execution unit, and the queue registers each one.
module sparse_matrix_assembly_csc #(
   parameter int MAX_ROWS    = 256,
   parameter int MAX_COLS    = 256,
   parameter int MAX_PER_COL = 16
) (
   input logic       clock,
   input logic       reset,
   smac_req_if.sink  req_bus,
   smac_rsp_if.source rsp_bus,
   smac_csr_if.sink  csr_bus
);
   import smac_pkg::*;

   logic    job_vld, job_rdy;
   job_type job;

   smac_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
      .clock(clock), .reset(reset), .req_bus(req_bus), .csr_bus(csr_bus),
      .job_vld(job_vld), .job(job), .job_rdy(job_rdy));

   smac_back #(.MAX_COLS(MAX_COLS), .MAX_PER_COL(MAX_PER_COL)) u_back (
      .clock(clock), .reset(reset), .job_vld(job_vld), .job(job), .job_rdy(job_rdy),
      .rsp_bus(rsp_bus));
endmodule
